FILE: sv/tgel_pkg.sv
package tgel_pkg;

  // Grid limits and derived widths
  localparam int MAX_ROWS   = 1024;
  localparam int MAX_COLS   = 1024;
  localparam int ROW_W      = $clog2(MAX_ROWS);
  localparam int COL_W      = $clog2(MAX_COLS);
  localparam int RSZ_W      = $clog2(MAX_ROWS + 1);
  localparam int CSZ_W      = $clog2(MAX_COLS + 1);
  localparam int BANK_RW    = ROW_W - 1;
  localparam int BANK_CW    = COL_W - 1;
  localparam int BANK_AW    = BANK_RW + BANK_CW;
  localparam int BANK_DEPTH = 1 << BANK_AW;

  // Grid position: Q.16 grid units
  localparam int FRAC_W    = 16;
  localparam int PROW_W    = ROW_W + FRAC_W;
  localparam int PCOL_W    = COL_W + FRAC_W;
  localparam int POS_W     = 41;
  localparam int HALF_POST = 1 << (FRAC_W - 1);

  // Configuration port
  localparam int CFG_AW = 6;
  localparam int CFG_DW = 64;

  // Register values as seen by the datapath; sizes already saturated
  typedef struct packed {
    logic signed [31:0] south_lat;
    logic signed [32:0] west_lon;
    logic signed [31:0] north_lat;
    logic signed [32:0] east_lon;
    logic [31:0]        lat_ppd;
    logic [31:0]        lon_ppd;
    logic [RSZ_W-1:0]   rows;
    logic [CSZ_W-1:0]   cols;
  } cfg_t;

  // Item leaving the index stage towards the post memory
  typedef struct packed {
    logic               wr_v;
    logic               q_v;
    logic               found;
    logic               interp;
    logic [ROW_W-1:0]   row;
    logic [COL_W-1:0]   col;
    logic [FRAC_W:0]    fr;
    logic [FRAC_W:0]    fc;
    logic signed [15:0] wdata;
  } idx_t;

  // Query side data that travels beside the memory read
  typedef struct packed {
    logic            found;
    logic            interp;
    logic            r0;
    logic            c0;
    logic [FRAC_W:0] fr;
    logic [FRAC_W:0] fc;
  } meta_t;

  // Read data of the four parity banks, indexed {row parity, col parity}
  typedef logic [3:0][15:0] bankq_t;

endpackage

FILE: sv/terrain_grid_elevation_lookup.sv
// Elevation lookup over a grid of 16-bit posts. Input beats with tuser 0
// write one post; beats with tuser 1 query a point and give exactly one
// result beat (tuser = found, tdata = height in Q16.8 metres, zero when the
// point is outside the corner box). The pipeline takes one beat per clock
// unless a finished result is blocked at the output; a write needs no
// result and costs one slot. The post store is four parity banks (even/odd
// row by even/odd column) of single-port memory, so the four corners of a
// bilinear cell come out in one access and writes share the same memory
// stage in order with queries. Posts hold nothing until written and there
// is no clearing pass; a query touching an unwritten post returns an
// undefined height. Registers must be changed only while no query is in
// flight; the block itself does not enforce this.
module terrain_grid_elevation_lookup import tgel_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  // post_row[9:0] post_col[19:10] post_height[35:20] query_lat[67:36]
  // query_lon[100:68] interpolate[101], zero pad[103:102]
  input  logic [103:0]      in_tdata,
  // action[0]
  input  logic [0:0]        in_tuser,
  output logic              out_tvalid,
  input  logic              out_tready,
  // height[23:0]
  output logic [23:0]       out_tdata,
  // found[0]
  output logic [0:0]        out_tuser,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [CFG_DW-1:0] cfg_pwdata,
  output logic [CFG_DW-1:0] cfg_prdata,
  output logic              cfg_pready
);

  cfg_t   cfg;
  idx_t   idx;
  meta_t  m_r;
  logic   m_v_r;
  bankq_t bank_q;
  logic [3:0]               bank_we;
  logic [3:0][BANK_AW-1:0]  bank_addr;
  logic [ROW_W-1:0]         row_inc;
  logic [COL_W-1:0]         col_inc;
  logic                     en, out_free, last_v, res_found;
  logic signed [23:0]       res_height;
  logic                     out_valid_r, out_found_r;
  logic [23:0]              out_height_r;

  // Pipeline moves unless a finished result is blocked at the output
  assign out_free  = !out_valid_r || out_tready;
  assign en        = out_free || !last_v;
  assign in_tready = en;

  tgel_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  tgel_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .en          (en),
    .in_v        (in_tvalid),
    .action      (in_tuser[0]),
    .post_row    (in_tdata[9:0]),
    .post_col    (in_tdata[19:10]),
    .post_height (in_tdata[35:20]),
    .query_lat   (in_tdata[67:36]),
    .query_lon   (in_tdata[100:68]),
    .interpolate (in_tdata[101]),
    .cfg         (cfg),
    .idx         (idx)
  );

  // Parity banks: a bank whose parity differs from the south-west index
  // serves the next row or column up
  assign row_inc = ROW_W'(idx.row + 1'b1);
  assign col_inc = COL_W'(idx.col + 1'b1);

  for (genvar k = 0; k < 4; k++) begin : g_bank
    localparam int RP = k / 2;
    localparam int CP = k % 2;
    logic [BANK_RW-1:0] brow;
    logic [BANK_CW-1:0] bcol;

    assign brow = (idx.row[0] == 1'(RP)) ? idx.row[ROW_W-1:1] : row_inc[ROW_W-1:1];
    assign bcol = (idx.col[0] == 1'(CP)) ? idx.col[COL_W-1:1] : col_inc[COL_W-1:1];
    assign bank_addr[k] = {bcol, brow};
    assign bank_we[k]   = en && idx.wr_v &&
                          (idx.row[0] == 1'(RP)) && (idx.col[0] == 1'(CP));

    tgel_bank u_bank (
      .clk     (clk),
      .en      (en),
      .we      (bank_we[k]),
      .addr    (bank_addr[k]),
      .wdata   (idx.wdata),
      .rdata_r (bank_q[k])
    );
  end

  // Query data alongside the memory read
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_v_r <= 1'b0;
    end else if (en) begin
      m_v_r <= idx.q_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_r.found  <= idx.found;
      m_r.interp <= idx.interp;
      m_r.r0     <= idx.row[0];
      m_r.c0     <= idx.col[0];
      m_r.fr     <= idx.fr;
      m_r.fc     <= idx.fc;
    end
  end

  tgel_blend u_blend (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (en),
    .m_v        (m_v_r),
    .meta       (m_r),
    .bank_q     (bank_q),
    .last_v     (last_v),
    .res_found  (res_found),
    .res_height (res_height)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= last_v;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      out_found_r  <= res_found;
      out_height_r <= res_height;
    end
  end

  assign out_tvalid   = out_valid_r;
  assign out_tuser[0] = out_found_r;
  assign out_tdata    = out_height_r;

  // Checks
  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result beat offered straight after reset");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> out_tdata == '0)
    else $error("not-found result carries a height");

  a_one_bank_write: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(bank_we))
    else $error("post written to more than one bank");

  a_stall_holds_mem: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(bank_q))
    else $error("bank read data changed during a stall");

endmodule

FILE: sv/tgel_cfg.sv
module tgel_cfg import tgel_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  localparam logic [2:0] REG_SOUTH_LAT = 3'd0;
  localparam logic [2:0] REG_WEST_LON  = 3'd1;
  localparam logic [2:0] REG_NORTH_LAT = 3'd2;
  localparam logic [2:0] REG_EAST_LON  = 3'd3;
  localparam logic [2:0] REG_LAT_PPD   = 3'd4;
  localparam logic [2:0] REG_LON_PPD   = 3'd5;
  localparam logic [2:0] REG_ROWS      = 3'd6;
  localparam logic [2:0] REG_COLS      = 3'd7;

  logic signed [31:0] south_lat_r;
  logic signed [32:0] west_lon_r;
  logic signed [31:0] north_lat_r;
  logic signed [32:0] east_lon_r;
  logic [31:0]        lat_ppd_r;
  logic [31:0]        lon_ppd_r;
  logic [10:0]        rows_r;
  logic [10:0]        cols_r;
  logic [2:0]         reg_sel;
  logic               wr_en;

  assign reg_sel = paddr[CFG_AW-1:3];
  assign wr_en   = psel & penable & pwrite;
  assign pready  = 1'b1;

  // Register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      south_lat_r <= '0;
      west_lon_r  <= '0;
      north_lat_r <= '0;
      east_lon_r  <= '0;
      lat_ppd_r   <= 32'd65536;
      lon_ppd_r   <= 32'd65536;
      rows_r      <= 11'd2;
      cols_r      <= 11'd2;
    end else if (wr_en) begin
      unique case (reg_sel)
        REG_SOUTH_LAT: south_lat_r <= pwdata[31:0];
        REG_WEST_LON:  west_lon_r  <= pwdata[32:0];
        REG_NORTH_LAT: north_lat_r <= pwdata[31:0];
        REG_EAST_LON:  east_lon_r  <= pwdata[32:0];
        REG_LAT_PPD:   lat_ppd_r   <= pwdata[31:0];
        REG_LON_PPD:   lon_ppd_r   <= pwdata[31:0];
        REG_ROWS:      rows_r      <= pwdata[10:0];
        REG_COLS:      cols_r      <= pwdata[10:0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    unique case (reg_sel)
      REG_SOUTH_LAT: prdata = CFG_DW'({south_lat_r});
      REG_WEST_LON:  prdata = CFG_DW'({west_lon_r});
      REG_NORTH_LAT: prdata = CFG_DW'({north_lat_r});
      REG_EAST_LON:  prdata = CFG_DW'({east_lon_r});
      REG_LAT_PPD:   prdata = CFG_DW'(lat_ppd_r);
      REG_LON_PPD:   prdata = CFG_DW'(lon_ppd_r);
      REG_ROWS:      prdata = CFG_DW'(rows_r);
      REG_COLS:      prdata = CFG_DW'(cols_r);
      default:       prdata = '0;
    endcase
  end

  // Datapath view; grid sizes saturated into 2..MAX
  always_comb begin
    cfg.south_lat = south_lat_r;
    cfg.west_lon  = west_lon_r;
    cfg.north_lat = north_lat_r;
    cfg.east_lon  = east_lon_r;
    cfg.lat_ppd   = lat_ppd_r;
    cfg.lon_ppd   = lon_ppd_r;
    if (32'(rows_r) < 32'd2)
      cfg.rows = RSZ_W'(2);
    else if (32'(rows_r) > 32'(MAX_ROWS))
      cfg.rows = RSZ_W'(MAX_ROWS);
    else
      cfg.rows = RSZ_W'(rows_r);
    if (32'(cols_r) < 32'd2)
      cfg.cols = CSZ_W'(2);
    else if (32'(cols_r) > 32'(MAX_COLS))
      cfg.cols = CSZ_W'(MAX_COLS);
    else
      cfg.cols = CSZ_W'(cols_r);
  end

endmodule

FILE: sv/tgel_front.sv
module tgel_front import tgel_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               in_v,
  input  logic               action,
  input  logic [9:0]         post_row,
  input  logic [9:0]         post_col,
  input  logic signed [15:0] post_height,
  input  logic signed [31:0] query_lat,
  input  logic signed [32:0] query_lon,
  input  logic               interpolate,
  input  cfg_t               cfg,
  output idx_t               idx
);

  // Stage 1: input register
  logic               a1_v_r, a1_act_r, a1_int_r;
  logic [9:0]         a1_row_r, a1_col_r;
  logic signed [15:0] a1_h_r;
  logic signed [31:0] a1_lat_r;
  logic signed [32:0] a1_lon_r;

  // Stage 2: bounds and offsets
  logic               a2_wv_r, a2_qv_r, a2_found_r, a2_int_r;
  logic [9:0]         a2_row_r, a2_col_r;
  logic signed [15:0] a2_h_r;
  logic [31:0]        a2_dlat_r;
  logic [32:0]        a2_dlon_r;

  // Stage 3: partial products
  logic               a3_wv_r, a3_qv_r, a3_found_r, a3_int_r;
  logic [9:0]         a3_row_r, a3_col_r;
  logic signed [15:0] a3_h_r;
  logic [47:0]        a3_lat_a_r, a3_lat_b_r;
  logic [48:0]        a3_lon_a_r, a3_lon_b_r;

  // Stage 4: grid position
  logic               a4_wv_r, a4_qv_r, a4_found_r, a4_int_r;
  logic [9:0]         a4_row_r, a4_col_r;
  logic signed [15:0] a4_h_r;
  logic [POS_W-1:0]   a4_lat_pos_r, a4_lon_pos_r;

  // Stage 5: position clamped to the last post
  logic               a5_wv_r, a5_qv_r, a5_found_r, a5_int_r;
  logic [9:0]         a5_row_r, a5_col_r;
  logic signed [15:0] a5_h_r;
  logic [PROW_W-1:0]  a5_prow_r;
  logic [PCOL_W-1:0]  a5_pcol_r;

  // Stage 6: post index and fractions
  logic               a6_wv_r, a6_qv_r, a6_found_r, a6_int_r;
  logic [ROW_W-1:0]   a6_row_r;
  logic [COL_W-1:0]   a6_col_r;
  logic [FRAC_W:0]    a6_fr_r, a6_fc_r;
  logic signed [15:0] a6_h_r;

  logic              found_nxt, wr_ok;
  logic [PROW_W-1:0] lim_row;
  logic [PCOL_W-1:0] lim_col;
  logic [ROW_W-1:0]  rf, rmax2, ri, rlast, rsel, row_nxt;
  logic [COL_W-1:0]  cf, cmax2, ci, clast, csel, col_nxt;
  logic [PROW_W:0]   rn_sum;
  logic [PCOL_W:0]   cn_sum;
  logic [ROW_W:0]    rn;
  logic [COL_W:0]    cn;
  logic [FRAC_W:0]   fr_nxt, fc_nxt;

  assign found_nxt = (a1_lat_r >= cfg.south_lat) && (a1_lat_r <= cfg.north_lat) &&
                     (a1_lon_r >= cfg.west_lon) && (a1_lon_r <= cfg.east_lon);
  assign wr_ok     = (32'(a1_row_r) < 32'(MAX_ROWS)) && (32'(a1_col_r) < 32'(MAX_COLS));
  assign lim_row   = {ROW_W'(cfg.rows - 1'b1), {FRAC_W{1'b0}}};
  assign lim_col   = {COL_W'(cfg.cols - 1'b1), {FRAC_W{1'b0}}};

  // Index selection: bilinear keeps one post of margin, nearest rounds
  always_comb begin
    rf     = a5_prow_r[PROW_W-1:FRAC_W];
    cf     = a5_pcol_r[PCOL_W-1:FRAC_W];
    rmax2  = ROW_W'(cfg.rows - 2'd2);
    cmax2  = COL_W'(cfg.cols - 2'd2);
    ri     = (rf > rmax2) ? rmax2 : rf;
    ci     = (cf > cmax2) ? cmax2 : cf;
    fr_nxt = (FRAC_W+1)'(a5_prow_r - {ri, {FRAC_W{1'b0}}});
    fc_nxt = (FRAC_W+1)'(a5_pcol_r - {ci, {FRAC_W{1'b0}}});
    rn_sum = (PROW_W+1)'(a5_prow_r) + (PROW_W+1)'(HALF_POST);
    cn_sum = (PCOL_W+1)'(a5_pcol_r) + (PCOL_W+1)'(HALF_POST);
    rn     = rn_sum[PROW_W:FRAC_W];
    cn     = cn_sum[PCOL_W:FRAC_W];
    rlast  = ROW_W'(cfg.rows - 1'b1);
    clast  = COL_W'(cfg.cols - 1'b1);
    rsel   = (rn > (ROW_W+1)'(rlast)) ? rlast : ROW_W'(rn);
    csel   = (cn > (COL_W+1)'(clast)) ? clast : COL_W'(cn);
    if (a5_wv_r) begin
      row_nxt = ROW_W'(a5_row_r);
      col_nxt = COL_W'(a5_col_r);
    end else if (a5_int_r) begin
      row_nxt = ri;
      col_nxt = ci;
    end else begin
      row_nxt = rsel;
      col_nxt = csel;
    end
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a1_v_r  <= 1'b0;
      a2_wv_r <= 1'b0;
      a2_qv_r <= 1'b0;
      a3_wv_r <= 1'b0;
      a3_qv_r <= 1'b0;
      a4_wv_r <= 1'b0;
      a4_qv_r <= 1'b0;
      a5_wv_r <= 1'b0;
      a5_qv_r <= 1'b0;
      a6_wv_r <= 1'b0;
      a6_qv_r <= 1'b0;
    end else if (en) begin
      a1_v_r  <= in_v;
      a2_wv_r <= a1_v_r & ~a1_act_r & wr_ok;
      a2_qv_r <= a1_v_r & a1_act_r;
      a3_wv_r <= a2_wv_r;
      a3_qv_r <= a2_qv_r;
      a4_wv_r <= a3_wv_r;
      a4_qv_r <= a3_qv_r;
      a5_wv_r <= a4_wv_r;
      a5_qv_r <= a4_qv_r;
      a6_wv_r <= a5_wv_r;
      a6_qv_r <= a5_qv_r;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (en) begin
      a1_act_r     <= action;
      a1_int_r     <= interpolate;
      a1_row_r     <= post_row;
      a1_col_r     <= post_col;
      a1_h_r       <= post_height;
      a1_lat_r     <= query_lat;
      a1_lon_r     <= query_lon;

      a2_found_r   <= found_nxt;
      a2_int_r     <= a1_int_r;
      a2_row_r     <= a1_row_r;
      a2_col_r     <= a1_col_r;
      a2_h_r       <= a1_h_r;
      a2_dlat_r    <= 32'(a1_lat_r - cfg.south_lat);
      a2_dlon_r    <= 33'(a1_lon_r - cfg.west_lon);

      a3_found_r   <= a2_found_r;
      a3_int_r     <= a2_int_r;
      a3_row_r     <= a2_row_r;
      a3_col_r     <= a2_col_r;
      a3_h_r       <= a2_h_r;
      a3_lat_a_r   <= a2_dlat_r * cfg.lat_ppd[31:16];
      a3_lat_b_r   <= a2_dlat_r * cfg.lat_ppd[15:0];
      a3_lon_a_r   <= a2_dlon_r * cfg.lon_ppd[31:16];
      a3_lon_b_r   <= a2_dlon_r * cfg.lon_ppd[15:0];

      a4_found_r   <= a3_found_r;
      a4_int_r     <= a3_int_r;
      a4_row_r     <= a3_row_r;
      a4_col_r     <= a3_col_r;
      a4_h_r       <= a3_h_r;
      a4_lat_pos_r <= POS_W'((66'({a3_lat_a_r, 16'b0}) + 66'(a3_lat_b_r)) >> 24);
      a4_lon_pos_r <= POS_W'((66'({a3_lon_a_r, 16'b0}) + 66'(a3_lon_b_r)) >> 24);

      a5_found_r   <= a4_found_r;
      a5_int_r     <= a4_int_r;
      a5_row_r     <= a4_row_r;
      a5_col_r     <= a4_col_r;
      a5_h_r       <= a4_h_r;
      a5_prow_r    <= (a4_lat_pos_r > POS_W'(lim_row)) ? lim_row : PROW_W'(a4_lat_pos_r);
      a5_pcol_r    <= (a4_lon_pos_r > POS_W'(lim_col)) ? lim_col : PCOL_W'(a4_lon_pos_r);

      a6_found_r   <= a5_found_r;
      a6_int_r     <= a5_int_r;
      a6_row_r     <= row_nxt;
      a6_col_r     <= col_nxt;
      a6_fr_r      <= fr_nxt;
      a6_fc_r      <= fc_nxt;
      a6_h_r       <= a5_h_r;
    end
  end

  always_comb begin
    idx.wr_v   = a6_wv_r;
    idx.q_v    = a6_qv_r;
    idx.found  = a6_found_r;
    idx.interp = a6_int_r;
    idx.row    = a6_row_r;
    idx.col    = a6_col_r;
    idx.fr     = a6_fr_r;
    idx.fc     = a6_fc_r;
    idx.wdata  = a6_h_r;
  end

endmodule

FILE: sv/tgel_bank.sv
module tgel_bank import tgel_pkg::*; (
  input  logic               clk,
  input  logic               en,
  input  logic               we,
  input  logic [BANK_AW-1:0] addr,
  input  logic [15:0]        wdata,
  output logic [15:0]        rdata_r
);

  logic [15:0] post_mem [BANK_DEPTH];

  // Single port, registered read; holds while the pipeline stalls
  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        post_mem[addr] <= wdata;
      end
      rdata_r <= post_mem[addr];
    end
  end

endmodule

FILE: sv/tgel_blend.sv
module tgel_blend import tgel_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               m_v,
  input  meta_t              meta,
  input  bankq_t             bank_q,
  output logic               last_v,
  output logic               res_found,
  output logic signed [23:0] res_height
);

  logic [1:0] k_sw, k_nw, k_se, k_ne;
  logic signed [15:0] sw, nw, se, ne;

  // Stage 1: corner routing and differences
  logic               b1_v_r, b1_found_r, b1_int_r;
  logic [FRAC_W:0]    b1_fr_r, b1_fc_r;
  logic signed [15:0] b1_sw_r, b1_se_r;
  logic signed [16:0] b1_dn_r, b1_ds_r;

  // Stage 2: row-direction products
  logic               b2_v_r, b2_found_r, b2_int_r;
  logic [FRAC_W:0]    b2_fc_r;
  logic signed [15:0] b2_sw_r, b2_se_r;
  logic signed [34:0] b2_pw_r, b2_pe_r;

  // Stage 3: west and east edge values, Q.16
  logic               b3_v_r, b3_found_r, b3_int_r;
  logic [FRAC_W:0]    b3_fc_r;
  logic signed [15:0] b3_sw_r;
  logic signed [34:0] b3_west_r, b3_east_r;

  // Stage 4: east minus west
  logic               b4_v_r, b4_found_r, b4_int_r;
  logic [FRAC_W:0]    b4_fc_r;
  logic signed [15:0] b4_sw_r;
  logic signed [34:0] b4_west_r;
  logic signed [35:0] b4_dwe_r;

  // Stage 5: column-direction product
  logic               b5_v_r, b5_found_r, b5_int_r;
  logic signed [15:0] b5_sw_r;
  logic signed [34:0] b5_west_r;
  logic signed [53:0] b5_pf_r;

  logic signed [53:0] val;

  always_comb begin
    k_sw = {meta.r0, meta.c0};
    k_nw = {~meta.r0, meta.c0};
    k_se = {meta.r0, ~meta.c0};
    k_ne = {~meta.r0, ~meta.c0};
    sw   = $signed(bank_q[k_sw]);
    nw   = $signed(bank_q[k_nw]);
    se   = $signed(bank_q[k_se]);
    ne   = $signed(bank_q[k_ne]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b1_v_r <= 1'b0;
      b2_v_r <= 1'b0;
      b3_v_r <= 1'b0;
      b4_v_r <= 1'b0;
      b5_v_r <= 1'b0;
    end else if (en) begin
      b1_v_r <= m_v;
      b2_v_r <= b1_v_r;
      b3_v_r <= b2_v_r;
      b4_v_r <= b3_v_r;
      b5_v_r <= b4_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b1_found_r <= meta.found;
      b1_int_r   <= meta.interp;
      b1_fr_r    <= meta.fr;
      b1_fc_r    <= meta.fc;
      b1_sw_r    <= sw;
      b1_se_r    <= se;
      b1_dn_r    <= 17'(nw) - 17'(sw);
      b1_ds_r    <= 17'(ne) - 17'(se);

      b2_found_r <= b1_found_r;
      b2_int_r   <= b1_int_r;
      b2_fc_r    <= b1_fc_r;
      b2_sw_r    <= b1_sw_r;
      b2_se_r    <= b1_se_r;
      b2_pw_r    <= 35'(b1_dn_r * $signed({1'b0, b1_fr_r}));
      b2_pe_r    <= 35'(b1_ds_r * $signed({1'b0, b1_fr_r}));

      b3_found_r <= b2_found_r;
      b3_int_r   <= b2_int_r;
      b3_fc_r    <= b2_fc_r;
      b3_sw_r    <= b2_sw_r;
      b3_west_r  <= $signed({{3{b2_sw_r[15]}}, b2_sw_r, 16'b0}) + b2_pw_r;
      b3_east_r  <= $signed({{3{b2_se_r[15]}}, b2_se_r, 16'b0}) + b2_pe_r;

      b4_found_r <= b3_found_r;
      b4_int_r   <= b3_int_r;
      b4_fc_r    <= b3_fc_r;
      b4_sw_r    <= b3_sw_r;
      b4_west_r  <= b3_west_r;
      b4_dwe_r   <= 36'(b3_east_r) - 36'(b3_west_r);

      b5_found_r <= b4_found_r;
      b5_int_r   <= b4_int_r;
      b5_sw_r    <= b4_sw_r;
      b5_west_r  <= b4_west_r;
      b5_pf_r    <= 54'(b4_dwe_r * $signed({1'b0, b4_fc_r}));
    end
  end

  // Final blend, floored to Q16.8; nearest post is the south-west read
  assign val    = $signed({{3{b5_west_r[34]}}, b5_west_r, 16'b0}) + b5_pf_r;
  assign last_v = b5_v_r;

  always_comb begin
    res_found = b5_found_r;
    if (!b5_found_r)
      res_height = '0;
    else if (b5_int_r)
      res_height = val[47:24];
    else
      res_height = {b5_sw_r, 8'b0};
  end

endmodule

FILE: sim/tb_terrain_grid_elevation_lookup.sv
module tb_terrain_grid_elevation_lookup;
  import tgel_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic   ACT_WRITE   = 1'b0;
  localparam logic   ACT_QUERY   = 1'b1;
  localparam logic   MODE_NEAR   = 1'b0;
  localparam logic   MODE_BLEND  = 1'b1;
  localparam longint DEG         = 64'sd16777216;
  localparam longint LAT_MIN     = -64'sd1509949440;
  localparam longint LAT_MAX     = 64'sd1509949440;
  localparam longint LON_MIN     = -64'sd3019898880;
  localparam longint LON_MAX     = 64'sd3019898880;
  localparam int     DRAIN_CYC   = 20;
  localparam int     STALL_LIMIT = 5000;
  localparam int     ITEM_TARGET = 1650;

  typedef enum int {
    REG_SOUTH_LAT = 0,
    REG_WEST_LON  = 1,
    REG_NORTH_LAT = 2,
    REG_EAST_LON  = 3,
    REG_LAT_PPD   = 4,
    REG_LON_PPD   = 5,
    REG_ROWS      = 6,
    REG_COLS      = 7
  } reg_idx_e;

  typedef struct packed {
    logic        found;
    logic [23:0] height;
  } elev_t;

  // Grid model, config copy and queue of awaited elevations
  class elevation_board;
    longint          south, west, north, east;
    longint unsigned lat_ppd, lon_ppd;
    int              rows, cols;
    logic signed [15:0] posts [int];
    elev_t           awaited[$];
    int              errors, n_writes, n_queries, n_found;

    function new();
      south = 0; west = 0; north = 0; east = 0;
      lat_ppd = 65536; lon_ppd = 65536;
      rows = 2; cols = 2;
      errors = 0; n_writes = 0; n_queries = 0; n_found = 0;
    endfunction

    function int sat_size(logic [10:0] v);
      if (v < 2) return 2;
      if (v > 1024) return 1024;
      return int'(v);
    endfunction

    function void set_reg(reg_idx_e idx, logic [63:0] v);
      case (idx)
        REG_SOUTH_LAT: south = longint'(signed'(v[31:0]));
        REG_WEST_LON:  west  = longint'({{31{v[32]}}, v[32:0]});
        REG_NORTH_LAT: north = longint'(signed'(v[31:0]));
        REG_EAST_LON:  east  = longint'({{31{v[32]}}, v[32:0]});
        REG_LAT_PPD:   lat_ppd = longint'(v[31:0]);
        REG_LON_PPD:   lon_ppd = longint'(v[31:0]);
        REG_ROWS:      rows = sat_size(v[10:0]);
        REG_COLS:      cols = sat_size(v[10:0]);
        default: ;
      endcase
    endfunction

    // Grid cell (blend) or post (nearest) addressed by a point, with fractions
    function void locate(longint lat, longint lon, logic blend, output logic hit,
                         output int r, output int c, output longint fr,
                         output longint fc);
      logic [127:0]    prod;
      longint unsigned prow, pcol, lim;
      hit = !(lat < south || lat > north || lon < west || lon > east);
      r = 0; c = 0; fr = 0; fc = 0;
      if (!hit) return;
      prod = 128'(unsigned'(lat - south)) * 128'(lat_ppd);
      prow = prod[87:24];
      prod = 128'(unsigned'(lon - west)) * 128'(lon_ppd);
      pcol = prod[87:24];
      lim = longint'(rows - 1) << 16;
      if (prow > lim) prow = lim;
      lim = longint'(cols - 1) << 16;
      if (pcol > lim) pcol = lim;
      if (blend) begin
        r = int'(prow >> 16);
        c = int'(pcol >> 16);
        if (r > rows - 2) r = rows - 2;
        if (c > cols - 2) c = cols - 2;
        fr = longint'(prow) - (longint'(r) << 16);
        fc = longint'(pcol) - (longint'(c) << 16);
      end else begin
        r = int'((prow + 32768) >> 16);
        c = int'((pcol + 32768) >> 16);
        if (r >= rows) r = rows - 1;
        if (c >= cols) c = cols - 1;
      end
    endfunction

    function longint post(int r, int c);
      return longint'(posts[c * 1024 + r]);
    endfunction

    function void note_beat(logic act, logic [9:0] r, logic [9:0] c,
                            logic [15:0] h, longint lat, longint lon, logic blend);
      logic   hit;
      int     pr, pc;
      longint fr, fc, sw, nw, se, ne, wv, ev, val;
      elev_t  e;
      if (act == ACT_WRITE) begin
        posts[int'(c) * 1024 + int'(r)] = h;
        n_writes++;
        return;
      end
      n_queries++;
      locate(lat, lon, blend, hit, pr, pc, fr, fc);
      e = '0;
      if (hit) begin
        n_found++;
        e.found = 1'b1;
        if (blend) begin
          sw = post(pr, pc);     nw = post(pr + 1, pc);
          se = post(pr, pc + 1); ne = post(pr + 1, pc + 1);
          wv = sw * 65536 + (nw - sw) * fr;
          ev = se * 65536 + (ne - se) * fr;
          val = wv * 65536 + (ev - wv) * fc;
          val = val >>> 24;
          e.height = val[23:0];
        end else begin
          val = post(pr, pc) * 256;
          e.height = val[23:0];
        end
      end
      awaited.push_back(e);
    endfunction

    function void check_result(logic found, logic [23:0] height);
      elev_t e;
      if (awaited.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result beat: found %0d height %h", found, height);
        return;
      end
      e = awaited.pop_front();
      if (e.found !== found || e.height !== height) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: expected found %0d height %h, got found %0d height %h",
                   e.found, e.height, found, height);
      end
    endfunction
  endclass

  logic          clk, rst_n;
  logic          in_tvalid, in_tready;
  logic [103:0]  in_tdata;
  logic [0:0]    in_tuser;
  logic          out_tvalid, out_tready;
  logic [23:0]   out_tdata;
  logic [0:0]    out_tuser;
  logic          cfg_psel, cfg_penable, cfg_pwrite;
  logic [CFG_AW-1:0] cfg_paddr;
  logic [CFG_DW-1:0] cfg_pwdata, cfg_prdata;
  logic          cfg_pready;

  elevation_board board = new();
  int  items, phases;
  int  idle_cyc = 0;
  bit  calm;

  terrain_grid_elevation_lookup dut (.*);

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  // Gap length: mostly none, some short, a few long
  function int gap_len();
    int p;
    if (calm) return 0;
    p = $urandom_range(0, 99);
    if (p < 60) return 0;
    if (p < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function longint rand_between(longint lo, longint hi);
    longint unsigned span;
    if (hi <= lo) return lo;
    span = longint'(hi - lo) + 1;
    return lo + longint'({$urandom, $urandom} % span);
  endfunction

  // Result side: random back-pressure, check at the rising edge
  always @(negedge clk) out_tready <= calm ? 1'b1 : (gap_len() == 0);

  always @(posedge clk)
    if (rst_n && out_tvalid && out_tready) board.check_result(out_tuser[0], out_tdata);

  // Watchdog on cycles without any accepted beat
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cyc <= 0;
    else idle_cyc <= idle_cyc + 1;
    if (idle_cyc >= STALL_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic send_beat(logic act, logic [9:0] r, logic [9:0] c, logic [15:0] h,
                           longint lat, longint lon, logic blend);
    repeat (gap_len()) @(negedge clk);
    in_tvalid = 1'b1;
    in_tuser  = act;
    in_tdata  = {2'b00, blend, lon[32:0], lat[31:0], h, c, r};
    do @(posedge clk); while (!in_tready);
    board.note_beat(act, r, c, h, lat, lon, blend);
    items++;
    @(negedge clk);
    in_tvalid = 1'b0;
  endtask

  task automatic send_post(int r, int c, logic [15:0] h);
    send_beat(ACT_WRITE, r[9:0], c[9:0], h, 0, 0, MODE_NEAR);
  endtask

  // Query, first loading any post it would read that holds nothing yet
  task automatic send_query(longint lat, longint lon, logic blend);
    logic   hit;
    int     r, c, span;
    longint fr, fc;
    board.locate(lat, lon, blend, hit, r, c, fr, fc);
    if (hit) begin
      span = blend ? 1 : 0;
      for (int dr = 0; dr <= span; dr++)
        for (int dc = 0; dc <= span; dc++)
          if (!board.posts.exists((c + dc) * 1024 + r + dr))
            send_post(r + dr, c + dc, 16'($urandom));
    end
    send_beat(ACT_QUERY, 10'($urandom), 10'($urandom), 16'($urandom), lat, lon, blend);
  endtask

  task automatic cfg_write(reg_idx_e idx, logic [63:0] v);
    cfg_psel = 1'b1; cfg_pwrite = 1'b1; cfg_penable = 1'b0;
    cfg_paddr = CFG_AW'(idx * 8); cfg_pwdata = v;
    @(negedge clk);
    cfg_penable = 1'b1;
    do @(posedge clk); while (!cfg_pready);
    board.set_reg(idx, v);
    @(negedge clk);
    cfg_psel = 1'b0; cfg_penable = 1'b0; cfg_pwrite = 1'b0;
  endtask

  // Let every query and any trailing write leave the pipeline
  task automatic drain();
    while (board.awaited.size() != 0) @(negedge clk);
    repeat (DRAIN_CYC) @(negedge clk);
  endtask

  task automatic set_grid(longint s, longint w, longint n, longint e,
                          logic [31:0] lppd, logic [31:0] cppd,
                          logic [10:0] nrows, logic [10:0] ncols);
    drain();
    cfg_write(REG_SOUTH_LAT, s);
    cfg_write(REG_WEST_LON, w);
    cfg_write(REG_NORTH_LAT, n);
    cfg_write(REG_EAST_LON, e);
    cfg_write(REG_LAT_PPD, lppd);
    cfg_write(REG_LON_PPD, cppd);
    cfg_write(REG_ROWS, nrows);
    cfg_write(REG_COLS, ncols);
    phases++;
    calm = ($urandom_range(0, 3) == 0);
  endtask

  // Mix of in-box, edge and anywhere points plus stray post writes
  task automatic random_items(int quota);
    int     stop, p;
    longint lat, lon;
    stop = items + quota;
    while (items < stop) begin
      p = $urandom_range(0, 99);
      if (p < 12) begin
        send_post($urandom_range(0, 1023), $urandom_range(0, 1023), 16'($urandom));
        continue;
      end
      if (p < 75) begin
        lat = rand_between(board.south, board.north);
        lon = rand_between(board.west, board.east);
      end else if (p < 88) begin
        case ($urandom_range(0, 3))
          0: lat = board.south - $urandom_range(0, 1);
          1: lat = board.north + $urandom_range(0, 1);
          2: lat = board.south;
          default: lat = board.north;
        endcase
        case ($urandom_range(0, 3))
          0: lon = board.west - $urandom_range(0, 1);
          1: lon = board.east + $urandom_range(0, 1);
          2: lon = board.west;
          default: lon = board.east;
        endcase
        if (lat < LAT_MIN) lat = LAT_MIN;
        if (lat > LAT_MAX) lat = LAT_MAX;
        if (lon < LON_MIN) lon = LON_MIN;
        if (lon > LON_MAX) lon = LON_MAX;
      end else begin
        lat = rand_between(LAT_MIN, LAT_MAX);
        lon = rand_between(LON_MIN, LON_MAX);
      end
      send_query(lat, lon, logic'($urandom));
    end
  endtask

  initial begin
    logic [127:0] q;
    int     nr, nc;
    longint s, w, n, e, lppd, cppd;
    rst_n = 1'b0; in_tvalid = 1'b0; in_tdata = '0; in_tuser = '0;
    cfg_psel = 1'b0; cfg_penable = 1'b0; cfg_pwrite = 1'b0;
    cfg_paddr = '0; cfg_pwdata = '0;
    items = 0; phases = 0; calm = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: reset corner box is a single point at the origin
    send_post(0, 0, 16'h7FFF);
    send_post(1, 0, 16'h8000);
    send_post(0, 1, 16'hFFFF);
    send_post(1, 1, 16'h0000);
    send_post(1023, 1023, 16'h5555);
    send_post(512, 511, 16'hAAAA);
    send_query(0, 0, MODE_BLEND);
    send_query(0, 0, MODE_NEAR);
    send_query(1, 0, MODE_BLEND);
    send_query(0, -1, MODE_NEAR);

    // Directed: small box, 9 x 10 posts, corners, edges and outside points
    set_grid(-2 * DEG, -3 * DEG, 2 * DEG, 3 * DEG, 32'd131072, 32'd98304, 11'd9, 11'd10);
    send_query(-2 * DEG, -3 * DEG, MODE_BLEND);
    send_query(2 * DEG, 3 * DEG, MODE_BLEND);
    send_query(2 * DEG, 3 * DEG, MODE_NEAR);
    send_query(DEG / 3, -DEG / 7, MODE_BLEND);
    send_query(DEG / 3, -DEG / 7, MODE_NEAR);
    send_query(-2 * DEG - 1, 0, MODE_BLEND);
    send_query(2 * DEG + 1, 0, MODE_NEAR);
    send_query(0, -3 * DEG - 1, MODE_BLEND);
    send_query(0, 3 * DEG + 1, MODE_NEAR);
    send_query(DEG / 4 + 16384, DEG / 3 + 8191, MODE_NEAR);
    random_items(80);

    // Widest box, largest scale, full-size grid
    set_grid(LAT_MIN, LON_MIN, LAT_MAX, LON_MAX, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
             11'd1024, 11'd1024);
    send_query(LAT_MIN, LON_MIN, MODE_BLEND);
    send_query(LAT_MAX, LON_MAX, MODE_NEAR);
    random_items(100);

    // Smallest scales and out-of-range sizes that saturate
    set_grid(LAT_MIN, LON_MIN, LAT_MAX, LON_MAX, 32'd1, 32'd0, 11'd0, 11'h7FF);
    random_items(80);

    // Corners swapped: nothing is inside
    set_grid(DEG, DEG, -DEG, -DEG, 32'd65536, 32'd65536, 11'd4, 11'd4);
    random_items(60);

    // Two by two grid over a tiny box
    set_grid(-100, -200, 100, 200, 32'hFFFF_FFFF, 32'h8000_0000, 11'd2, 11'd2);
    random_items(80);

    // Random grids sized so points spread over the posts
    while (items < ITEM_TARGET) begin
      nr = ($urandom_range(0, 7) == 0) ? 1024 : $urandom_range(2, 16);
      nc = ($urandom_range(0, 7) == 0) ? 1024 : $urandom_range(2, 16);
      s = rand_between(LAT_MIN, LAT_MAX - 1);
      n = rand_between(s + 1, (s + 20 * DEG > LAT_MAX) ? LAT_MAX : s + 20 * DEG);
      w = rand_between(LON_MIN, LON_MAX - 1);
      e = rand_between(w + 1, (w + 20 * DEG > LON_MAX) ? LON_MAX : w + 20 * DEG);
      q = (128'(nr - 1) << 40) / 128'(n - s);
      lppd = (q > 128'hFFFF_FFFF) ? 64'hFFFF_FFFF : longint'(q[31:0]) + 1;
      q = (128'(nc - 1) << 40) / 128'(e - w);
      cppd = (q > 128'hFFFF_FFFF) ? 64'hFFFF_FFFF : longint'(q[31:0]) + 1;
      set_grid(s, w, n, e, 32'(lppd), 32'(cppd), 11'(nr), 11'(nc));
      random_items(120);
    end

    drain();
    $display("covered %0d phases: %0d post writes, %0d queries (%0d inside the box)",
             phases, board.n_writes, board.n_queries, board.n_found);
    $display("directed corners, edges, saturated sizes and scales, swapped corners, random grids");
    if (board.errors == 0 && board.awaited.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

FILE: files.f
sv/tgel_pkg.sv
sv/tgel_cfg.sv
sv/tgel_front.sv
sv/tgel_bank.sv
sv/tgel_blend.sv
sv/terrain_grid_elevation_lookup.sv
sim/tb_terrain_grid_elevation_lookup.sv
